[rtl/core/pbrs_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and codes of the partition byte-range block splitter.
// Used by the channel interfaces and by every module of the block.
package pbrs_pkg;

   localparam int unsigned BLK_SHIFT  = 9;
   localparam int unsigned BLK_BYTES  = 512;
   localparam int unsigned ADDR_W     = 32;
   localparam int unsigned POS_W      = 33;
   localparam int unsigned CNT_W      = 15;
   localparam int unsigned LEFT_W     = CNT_W - BLK_SHIFT;
   localparam int unsigned BADDR_W    = 24;
   localparam int unsigned BCNT_W     = 9;
   localparam int unsigned IDX_W      = 6;
   localparam int unsigned ECNT_W     = 7;
   localparam int unsigned CSR_DATA_W = 9;
   localparam int unsigned CSR_IDX_W  = 1;

   localparam int unsigned TABLE_ENTRIES_DEF     = 64;
   localparam int unsigned MAX_REQUEST_BYTES_DEF = 16384;
   localparam int unsigned QUEUE_DEPTH           = 2;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;

   localparam logic [1:0] STAT_CMD  = 2'd0;
   localparam logic [1:0] STAT_DONE = 2'd1;
   localparam logic [1:0] STAT_ERR  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BLOCKS  = 1'b1;

   localparam logic [ECNT_W-1:0] ENTRY_COUNT_RST = 7'd0;
   localparam logic [BCNT_W-1:0] MAX_BLOCKS_RST  = 9'd128;

   typedef struct packed {
      logic [1:0]        kind;
      logic [IDX_W-1:0]  entry_index;
      logic [ADDR_W-1:0] byte_offset;
      logic [CNT_W-1:0]  byte_count;
      logic [ADDR_W-1:0] entry_start;
      logic [ADDR_W-1:0] entry_length;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [BADDR_W-1:0] block_address;
      logic [BCNT_W-1:0]  block_count;
      logic               is_write;
      logic               partial_block;
      logic [8:0]         first_byte;
      logic [CNT_W-1:0]   byte_length;
      logic [CNT_W-1:0]   total_bytes;
      logic               last;
   } rsp_item_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] length;
   } entry_type;

   // One checked request, handed from the front end to the command sequencer.
   typedef struct packed {
      logic             err;
      logic             is_write;
      logic [POS_W-1:0] pos;
      logic [CNT_W-1:0] size;
   } desc_type;

endpackage

[rtl/core/pbrs_req_if.sv]
`timescale 1ns / 1ps
// Request channel: valid/ready handshake carrying one request item per beat.
// Depends on pbrs_pkg.
interface pbrs_req_if;
   import pbrs_pkg::*;

   logic         valid;
   logic         ready;
   req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

[rtl/core/pbrs_rsp_if.sv]
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one result item per beat.
// Depends on pbrs_pkg.
interface pbrs_rsp_if;
   import pbrs_pkg::*;

   logic         valid;
   logic         ready;
   rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

[rtl/core/pbrs_front.sv]
`timescale 1ns / 1ps
// Front end: accepts request beats, keeps the partition table memory,
// checks and clips requests. Depends on pbrs_pkg and pbrs_req_if.
module pbrs_front #(
   parameter int unsigned TABLE_ENTRIES     = pbrs_pkg::TABLE_ENTRIES_DEF,
   parameter int unsigned MAX_REQUEST_BYTES = pbrs_pkg::MAX_REQUEST_BYTES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   pbrs_req_if.sink                   req,
   input  logic [pbrs_pkg::ECNT_W-1:0] entry_count,
   output logic                       desc_valid,
   output pbrs_pkg::desc_type         desc,
   input  logic                       desc_ready
);
   import pbrs_pkg::*;

   localparam int unsigned TBL_AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   typedef enum logic [1:0] {F_IDLE, F_SUM, F_CHECK} fstate_type;

   fstate_type       state_ff, state_in;
   logic             wr_ff, wr_in;
   logic             bad_ff, bad_in;
   logic [ADDR_W-1:0] off_ff, off_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] end_ff, end_in;

   entry_type        table_mem [TABLE_ENTRIES];
   entry_type        rd_ff;
   logic [TBL_AW-1:0] tbl_addr;
   logic             in_table;
   logic             accept;
   logic             is_req;
   logic [POS_W-1:0] room;
   logic             out_of_part;

   assign tbl_addr = TBL_AW'(req.item.entry_index);
   assign in_table = 32'(req.item.entry_index) < 32'(TABLE_ENTRIES);
   assign req.ready = (state_ff == F_IDLE);
   assign accept = req.valid && req.ready;
   assign is_req = (req.item.kind == KIND_READ) || (req.item.kind == KIND_WRITE);

   always_ff @(posedge clock) begin
      if (accept && (req.item.kind == KIND_LOAD) && in_table) begin
         table_mem[tbl_addr] <= '{start: req.item.entry_start, length: req.item.entry_length};
      end
      rd_ff <= table_mem[tbl_addr];
   end

   assign room = end_ff - pos_ff;
   assign out_of_part = (pos_ff >= end_ff);
   assign desc_valid = (state_ff == F_CHECK);
   assign desc.err = bad_ff || out_of_part;
   assign desc.is_write = wr_ff;
   assign desc.pos = pos_ff;
   assign desc.size = (room < POS_W'(cnt_ff)) ? room[CNT_W-1:0] : cnt_ff;

   always_comb begin
      state_in = state_ff;
      wr_in = wr_ff;
      bad_in = bad_ff;
      off_in = off_ff;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      end_in = end_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept && is_req) begin
               state_in = F_SUM;
               wr_in = (req.item.kind == KIND_WRITE);
               bad_in = ({1'b0, req.item.entry_index} >= entry_count) || !in_table ||
                        (req.item.byte_count == '0);
               off_in = req.item.byte_offset;
               // cut oversized requests before the partition-end clip
               cnt_in = (32'(req.item.byte_count) > 32'(MAX_REQUEST_BYTES)) ?
                        CNT_W'(MAX_REQUEST_BYTES) : req.item.byte_count;
            end
         end
         F_SUM: begin
            pos_in = POS_W'(rd_ff.start) + POS_W'(off_ff);
            end_in = POS_W'(rd_ff.start) + POS_W'(rd_ff.length);
            state_in = F_CHECK;
         end
         F_CHECK: begin
            if (desc_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      wr_ff <= wr_in;
      bad_ff <= bad_in;
      off_ff <= off_in;
      cnt_ff <= cnt_in;
      pos_ff <= pos_in;
      end_ff <= end_in;
   end

   // a request that passes the checks always moves at least one byte
   a_ok_nonempty: assert property (@(posedge clock) disable iff (reset)
      desc_valid && !desc.err |-> desc.size != '0)
      else $error("accepted request with empty size");

   // no request beat is taken while a check is in flight
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      $past(accept) && $past(is_req) && !$past(reset) |-> !req.ready)
      else $error("request taken while front end busy");

endmodule

[rtl/core/pbrs_queue.sv]
`timescale 1ns / 1ps
// Short descriptor queue between the front end and the command sequencer.
// Depends on pbrs_pkg.
module pbrs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  pbrs_pkg::desc_type in_desc,
   output logic               out_valid,
   input  logic               out_ready,
   output pbrs_pkg::desc_type out_desc
);
   import pbrs_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_QW-1:0] FULL = CNT_QW'(QUEUE_DEPTH);

   desc_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] count_ff, count_in;
   logic              push, pop;

   assign in_ready = (count_ff != FULL);
   assign out_valid = (count_ff != '0);
   assign out_desc = slot_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_desc;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("queue count beyond depth");

endmodule

[rtl/core/pbrs_back.sv]
`timescale 1ns / 1ps
// Command sequencer: splits one checked request into head, chunk and tail
// block commands and a closing status beat. Depends on pbrs_pkg, pbrs_rsp_if.
module pbrs_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         desc_valid,
   output logic                         desc_ready,
   input  pbrs_pkg::desc_type           desc,
   input  logic [pbrs_pkg::BCNT_W-1:0]  max_blocks,
   pbrs_rsp_if.source                   rsp
);
   import pbrs_pkg::*;

   typedef enum logic [2:0] {B_IDLE, B_HEAD, B_BODY, B_TAIL, B_DONE, B_ERR} bstate_type;

   bstate_type       state_ff, state_in;
   logic             wr_ff, wr_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] size_ff, size_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff, rsp_item_in;

   logic              can_emit;
   logic              emit;
   rsp_item_type      cmd;
   logic [9:0]        head_room;
   logic [CNT_W-1:0]  head_len;
   logic [LEFT_W-1:0] left;
   logic [BCNT_W-1:0] maxb;
   logic [BCNT_W-1:0] chunk;
   logic [CNT_W-1:0]  chunk_bytes;

   assign can_emit = !rsp_valid_ff || rsp.ready;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.item = rsp_item_ff;
   assign desc_ready = (state_ff == B_IDLE);

   assign head_room = 10'(BLK_BYTES) - {1'b0, pos_ff[BLK_SHIFT-1:0]};
   assign head_len = (CNT_W'(head_room) > size_ff) ? size_ff : CNT_W'(head_room);
   assign left = size_ff[CNT_W-1:BLK_SHIFT];
   assign maxb = (max_blocks == '0) ? BCNT_W'(1) : max_blocks;
   assign chunk = (BCNT_W'(left) > maxb) ? maxb : BCNT_W'(left);
   assign chunk_bytes = {chunk[LEFT_W-1:0], {BLK_SHIFT{1'b0}}};

   always_comb begin
      state_in = state_ff;
      wr_in = wr_ff;
      pos_in = pos_ff;
      size_in = size_ff;
      total_in = total_ff;
      emit = 1'b0;
      cmd = '0;
      cmd.block_address = pos_ff[POS_W-1:BLK_SHIFT];
      cmd.is_write = wr_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (desc_valid) begin
               wr_in = desc.is_write;
               pos_in = desc.pos;
               size_in = desc.size;
               total_in = desc.size;
               if (desc.err) begin
                  state_in = B_ERR;
               end else if (desc.pos[BLK_SHIFT-1:0] != '0) begin
                  state_in = B_HEAD;
               end else begin
                  state_in = B_BODY;
               end
            end
         end
         B_HEAD: begin
            cmd.block_count = BCNT_W'(1);
            cmd.partial_block = 1'b1;
            cmd.first_byte = pos_ff[BLK_SHIFT-1:0];
            cmd.byte_length = head_len;
            if (can_emit) begin
               emit = 1'b1;
               pos_in = pos_ff + POS_W'(head_len);
               size_in = size_ff - head_len;
               state_in = B_BODY;
            end
         end
         B_BODY: begin
            cmd.block_count = chunk;
            cmd.byte_length = chunk_bytes;
            if (left == '0) begin
               state_in = B_TAIL;
            end else if (can_emit) begin
               emit = 1'b1;
               pos_in = pos_ff + POS_W'(chunk_bytes);
               size_in = size_ff - chunk_bytes;
            end
         end
         B_TAIL: begin
            cmd.block_count = BCNT_W'(1);
            cmd.partial_block = 1'b1;
            cmd.byte_length = size_ff;
            if (size_ff == '0) begin
               state_in = B_DONE;
            end else if (can_emit) begin
               emit = 1'b1;
               size_in = '0;
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            cmd = '0;
            cmd.status = STAT_DONE;
            cmd.total_bytes = total_ff;
            cmd.last = 1'b1;
            if (can_emit) begin
               emit = 1'b1;
               state_in = B_IDLE;
            end
         end
         B_ERR: begin
            cmd = '0;
            cmd.status = STAT_ERR;
            cmd.last = 1'b1;
            if (can_emit) begin
               emit = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
      // hold the output beat until taken, load a new one when emitted
      rsp_valid_in = emit || (rsp_valid_ff && !rsp.ready);
      rsp_item_in = emit ? cmd : rsp_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      wr_ff <= wr_in;
      pos_ff <= pos_in;
      size_ff <= size_in;
      total_ff <= total_in;
      rsp_item_ff <= rsp_item_in;
   end

   a_cmd_moves_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.status == STAT_CMD |-> rsp_item_ff.byte_length != '0)
      else $error("block command with zero length");

   a_status_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.status != STAT_CMD |-> rsp_item_ff.last)
      else $error("status beat without last");

   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != B_IDLE && state_ff != B_ERR |-> size_ff <= total_ff)
      else $error("remaining size exceeds request total");

endmodule

[rtl/core/partition_byte_range_block_splitter.sv]
`timescale 1ns / 1ps
// Flow: a read or write request passes the front end (table read, address sums, range
// check and clip), then waits in a 2-deep queue for the command sequencer; load beats
// give no result beat. The front end takes no new request beat until its check is
// handed on, and the sequencer takes the next descriptor only after the closing status
// beat of the last one, sending its beats as the result channel takes them.
// Synchronous active-high reset clears control state, entry_count to 0 and
// max_blocks_per_cmd to 128; the partition table holds no value until loaded.
module partition_byte_range_block_splitter #(
   parameter int unsigned TABLE_ENTRIES     = pbrs_pkg::TABLE_ENTRIES_DEF,
   parameter int unsigned MAX_REQUEST_BYTES = pbrs_pkg::MAX_REQUEST_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   pbrs_req_if.sink                            req_ch,
   pbrs_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [pbrs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pbrs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pbrs_pkg::*;

   logic [ECNT_W-1:0] entry_count_ff;
   logic [BCNT_W-1:0] max_blocks_ff;

   logic     fq_valid, fq_ready;
   desc_type fq_desc;
   logic     qb_valid, qb_ready;
   desc_type qb_desc;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= ENTRY_COUNT_RST;
         max_blocks_ff <= MAX_BLOCKS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENTRY_COUNT: entry_count_ff <= csr_wdata[ECNT_W-1:0];
            CSR_MAX_BLOCKS:  max_blocks_ff <= csr_wdata[BCNT_W-1:0];
            default: ;
         endcase
      end
   end

   pbrs_front #(
      .TABLE_ENTRIES     (TABLE_ENTRIES),
      .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .entry_count (entry_count_ff),
      .desc_valid  (fq_valid),
      .desc        (fq_desc),
      .desc_ready  (fq_ready)
   );

   pbrs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_desc   (fq_desc),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_desc  (qb_desc)
   );

   pbrs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (qb_valid),
      .desc_ready (qb_ready),
      .desc       (qb_desc),
      .max_blocks (max_blocks_ff),
      .rsp        (rsp_ch)
   );

endmodule
